// ===== sv/spim_pkg.sv =====
// shared types and constants of the spi master controller
package spim_pkg;

   // bus operation codes carried by an input beat
   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_WRITE       = 2'd1,
      OP_READ_DATA   = 2'd2,
      OP_READ_STATUS = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_ENABLE          = 3'd0,
      CSR_WORD_16         = 3'd1,
      CSR_CLOCK_MODE_HIGH = 3'd2,
      CSR_PRESCALER       = 3'd3,
      CSR_SELECT_OE       = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 3;
   localparam int WORD_W      = 16;
   localparam int BITS_W      = 5;

   // depth of the command queue and of the result queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // classified command, front to back
   typedef struct packed {
      logic              is_tick;
      logic              is_write;
      logic              is_read_data;
      logic              is_read_status;
      logic [WORD_W-1:0] write_data;
      logic              miso;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              tx_empty;
      logic              rx_not_empty;
      logic              busy_res;
      logic              overrun;
      logic              sclk_out;
      logic              mosi_out;
      logic              select_out;
   } rsp_type;

   // configuration write beat
   typedef struct packed {
      logic                   write_enable;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_type;

endpackage

// ===== sv/spim_fifo.sv =====
// small register queue used between the front, the back and the result ports
module spim_fifo
   import spim_pkg::*;
#(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/spim_front.sv =====
// front end: accepts input beats, classifies the operation, queues commands
module spim_front
   import spim_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_operation,
   input  logic [WORD_W-1:0] req_write_data,
   input  logic              req_miso_in,
   input  logic              cmd_pop,
   output cmd_type           cmd,
   output logic              cmd_empty
);

   cmd_type decoded;

   always_comb begin
      decoded                = '0;
      decoded.write_data     = req_write_data;
      decoded.miso           = req_miso_in;
      case (op_type'(req_operation))
         OP_TICK:        decoded.is_tick        = 1'b1;
         OP_WRITE:       decoded.is_write       = 1'b1;
         OP_READ_DATA:   decoded.is_read_data   = 1'b1;
         OP_READ_STATUS: decoded.is_read_status = 1'b1;
         default:        decoded.is_tick        = 1'b0;
      endcase
   end

   spim_fifo #(.item_type(cmd_type)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (decoded),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

endmodule

// ===== sv/spim_back.sv =====
// back end: configuration, transmit and receive buffers, shifter and sck divider
module spim_back
   import spim_pkg::*;
#(
   parameter int PRESCALER_STEPS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  cmd_type cmd,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   localparam int HALF_W = PRESCALER_STEPS;

   // configuration
   logic enable_ff, word_16_ff, mode_high_ff, select_oe_ff;
   logic [2:0] prescaler_ff;

   // transfer state
   logic [WORD_W-1:0] tx_buffer_ff, tx_buffer_in;
   logic              tx_full_ff, tx_full_in;
   logic [WORD_W-1:0] shift_word_ff, shift_word_in;
   logic [WORD_W-1:0] rx_buffer_ff, rx_buffer_in;
   logic              rx_full_ff, rx_full_in;
   logic              overrun_ff, overrun_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic [HALF_W-1:0] half_count_ff, half_count_in;
   logic              clock_level_ff, clock_level_in;
   logic              shifting_ff, shifting_in;
   logic              mosi_ff, mosi_in;

   logic              execute;
   logic [WORD_W-1:0] word_mask, loaded, shifted;
   logic [2:0]        eff_prescaler;
   logic [HALF_W-1:0] period, count_next;
   logic              overrun_shown;

   assign execute  = !cmd_empty && !rsp_full;
   assign cmd_pop  = execute;
   assign rsp_push = execute;

   assign word_mask     = word_16_ff ? 16'hFFFF : 16'h00FF;
   assign loaded        = tx_buffer_ff & word_mask;
   assign shifted       = {shift_word_ff[WORD_W-2:0], cmd.miso} & word_mask;
   assign eff_prescaler = (32'(prescaler_ff) >= PRESCALER_STEPS)
                          ? 3'(PRESCALER_STEPS - 1) : prescaler_ff;
   assign period        = HALF_W'(1) << eff_prescaler;
   assign count_next    = half_count_ff + 1'b1;

   always_comb begin
      tx_buffer_in   = tx_buffer_ff;
      tx_full_in     = tx_full_ff;
      shift_word_in  = shift_word_ff;
      rx_buffer_in   = rx_buffer_ff;
      rx_full_in     = rx_full_ff;
      overrun_in     = overrun_ff;
      bits_left_in   = bits_left_ff;
      half_count_in  = half_count_ff;
      clock_level_in = clock_level_ff;
      shifting_in    = shifting_ff;
      mosi_in        = mosi_ff;

      if (cmd.is_tick && enable_ff) begin
         if (!shifting_ff) begin
            if (tx_full_ff) begin
               shift_word_in  = loaded;
               tx_full_in     = 1'b0;
               bits_left_in   = word_16_ff ? BITS_W'(16) : BITS_W'(8);
               half_count_in  = '0;
               clock_level_in = mode_high_ff;
               mosi_in        = word_16_ff ? loaded[15] : loaded[7];
               shifting_in    = 1'b1;
            end
         end else if (count_next < period) begin
            half_count_in = count_next;
         end else begin
            half_count_in  = '0;
            clock_level_in = !clock_level_ff;
            if (!clock_level_ff) begin
               // rising sck: sample miso
               shift_word_in = shifted;
               if (bits_left_ff != '0) begin
                  bits_left_in = bits_left_ff - 1'b1;
               end
            end else if (bits_left_ff != '0) begin
               // falling sck: drive next bit
               mosi_in = word_16_ff ? shift_word_ff[15] : shift_word_ff[7];
            end
            if (bits_left_in == '0 && clock_level_in == mode_high_ff) begin
               if (rx_full_ff) begin
                  overrun_in = 1'b1;
               end
               rx_buffer_in = shift_word_in & word_mask;
               rx_full_in   = 1'b1;
               shifting_in  = 1'b0;
            end
         end
      end

      if (cmd.is_write) begin
         tx_buffer_in = cmd.write_data;
         tx_full_in   = 1'b1;
      end
      if (cmd.is_read_data) begin
         rx_full_in = 1'b0;
      end

      overrun_shown = overrun_in;
      if (cmd.is_read_status) begin
         overrun_in = 1'b0;
      end

      rsp.read_data    = cmd.is_read_data ? rx_buffer_ff : '0;
      rsp.tx_empty     = !tx_full_in;
      rsp.rx_not_empty = rx_full_in;
      rsp.busy_res     = shifting_in || tx_full_in;
      rsp.overrun      = overrun_shown;
      rsp.sclk_out     = shifting_in ? clock_level_in : mode_high_ff;
      rsp.mosi_out     = mosi_in;
      rsp.select_out   = !(enable_ff && select_oe_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         word_16_ff   <= 1'b0;
         mode_high_ff <= 1'b0;
         prescaler_ff <= '0;
         select_oe_ff <= 1'b0;
      end else if (csr.write_enable) begin
         case (csr.index)
            CSR_ENABLE:          enable_ff    <= csr.write_data[0];
            CSR_WORD_16:         word_16_ff   <= csr.write_data[0];
            CSR_CLOCK_MODE_HIGH: mode_high_ff <= csr.write_data[0];
            CSR_PRESCALER:       prescaler_ff <= csr.write_data;
            CSR_SELECT_OE:       select_oe_ff <= csr.write_data[0];
            default:             enable_ff    <= enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_buffer_ff   <= '0;
         tx_full_ff     <= 1'b0;
         shift_word_ff  <= '0;
         rx_buffer_ff   <= '0;
         rx_full_ff     <= 1'b0;
         overrun_ff     <= 1'b0;
         bits_left_ff   <= '0;
         half_count_ff  <= '0;
         clock_level_ff <= 1'b0;
         shifting_ff    <= 1'b0;
         mosi_ff        <= 1'b0;
      end else if (execute) begin
         tx_buffer_ff   <= tx_buffer_in;
         tx_full_ff     <= tx_full_in;
         shift_word_ff  <= shift_word_in;
         rx_buffer_ff   <= rx_buffer_in;
         rx_full_ff     <= rx_full_in;
         overrun_ff     <= overrun_in;
         bits_left_ff   <= bits_left_in;
         half_count_ff  <= half_count_in;
         clock_level_ff <= clock_level_in;
         shifting_ff    <= shifting_in;
         mosi_ff        <= mosi_in;
      end
   end

endmodule

// ===== sv/spi_master_controller.sv =====
// top level of the spi master controller
//
//   channel  | ports                              | beat taken when
//   ---------+------------------------------------+-------------------------
//   request  | push, full, req_*                  | push high, full low
//   response | empty, pop, rsp_*                  | pop high, empty low
//   config   | csr_write_enable, csr_index, data  | csr_write_enable high
//
// one beat per cycle sustained while the result queue has room: each beat is one register update of the back end
// an accepted request beat is registered in the command queue, then the back end
// writes its response beat into the result queue
// reset is synchronous; both queues come out empty and all back end registers read zero
// a stalled response side fills the result queue, then the command queue,
// and full rises only once both are full
module spi_master_controller
   import spim_pkg::*;
#(
   parameter int PRESCALER_STEPS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   push,
   output logic                   full,
   input  logic [1:0]             req_operation,
   input  logic [WORD_W-1:0]      req_write_data,
   input  logic                   req_miso_in,
   // response side
   output logic                   empty,
   input  logic                   pop,
   output logic [WORD_W-1:0]      rsp_read_data,
   output logic                   rsp_tx_empty,
   output logic                   rsp_rx_not_empty,
   output logic                   rsp_busy_res,
   output logic                   rsp_overrun,
   output logic                   rsp_sclk_out,
   output logic                   rsp_mosi_out,
   output logic                   rsp_select_out,
   // configuration
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cmd_type cmd;
   logic    cmd_empty, cmd_pop;
   rsp_type rsp_new, rsp_head;
   logic    rsp_full, rsp_push;
   csr_type csr;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   // front: classify the beat and queue it
   spim_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_operation  (req_operation),
      .req_write_data (req_write_data),
      .req_miso_in    (req_miso_in),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd),
      .cmd_empty      (cmd_empty)
   );

   // back: runs one command per cycle while the result queue has room
   spim_back #(.PRESCALER_STEPS(PRESCALER_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   // result queue decouples the back end from the consumer
   spim_fifo #(.item_type(rsp_type)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign rsp_read_data    = rsp_head.read_data;
   assign rsp_tx_empty     = rsp_head.tx_empty;
   assign rsp_rx_not_empty = rsp_head.rx_not_empty;
   assign rsp_busy_res     = rsp_head.busy_res;
   assign rsp_overrun      = rsp_head.overrun;
   assign rsp_sclk_out     = rsp_head.sclk_out;
   assign rsp_mosi_out     = rsp_head.mosi_out;
   assign rsp_select_out   = rsp_head.select_out;

endmodule

// ===== sv/spim_checker.sv =====
// port level checks of the spi master controller and their bind
module spim_checker
   import spim_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input logic [WORD_W-1:0]      rsp_read_data,
   input logic                   rsp_tx_empty,
   input logic                   rsp_rx_not_empty,
   input logic                   rsp_busy_res,
   input logic                   rsp_overrun,
   input logic                   rsp_sclk_out,
   input logic                   rsp_mosi_out,
   input logic                   rsp_select_out
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a waiting response beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_read_data) && $stable(rsp_overrun)
                            && $stable(rsp_busy_res) && $stable(rsp_sclk_out)
                            && $stable(rsp_tx_empty) && $stable(rsp_rx_not_empty)
                            && $stable(rsp_mosi_out) && $stable(rsp_select_out)))
      else $error("response beat changed while stalled");

   // a full transmit buffer means the block reports busy
   a_busy_tx: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_tx_empty) |-> rsp_busy_res)
      else $error("transmit buffer full but not busy");

   // without any response beat waiting the request side cannot be full
   a_full_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("request side full while response queue empty");

endmodule

bind spi_master_controller spim_checker u_spim_checker (.*);

// ===== bench/spi_master_controller_check.sv =====
// channel monitor, status predictor and response checker for the spi master controller
module spi_master_controller_check
   import spim_pkg::*;
#(
   parameter int PRESCALER_STEPS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic [1:0]             req_operation,
   input  logic [WORD_W-1:0]      req_write_data,
   input  logic                   req_miso_in,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [WORD_W-1:0]      rsp_read_data,
   input  logic                   rsp_tx_empty,
   input  logic                   rsp_rx_not_empty,
   input  logic                   rsp_busy_res,
   input  logic                   rsp_overrun,
   input  logic                   rsp_sclk_out,
   input  logic                   rsp_mosi_out,
   input  logic                   rsp_select_out,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned            error_count,
   output int unsigned            beats_owed
);

   // configuration copy
   logic       cfg_enable;
   logic       cfg_word_16;
   logic       cfg_mode_high;
   logic [2:0] cfg_prescaler;
   logic       cfg_select_oe;

   // serial engine copy
   logic [WORD_W-1:0] tx_word;
   logic              tx_loaded;
   logic [WORD_W-1:0] shift_reg;
   logic [WORD_W-1:0] rx_word;
   logic              rx_loaded;
   logic              overrun_seen;
   logic [BITS_W-1:0] bits_to_go;
   logic [7:0]        half_count;
   logic              sck_level;
   logic              shifting;
   logic              mosi_level;

   rsp_type     status_due[$];
   int unsigned errors;
   int unsigned beat_no;

   function automatic logic [WORD_W-1:0] word_mask();
      return cfg_word_16 ? 16'hffff : 16'h00ff;
   endfunction

   function automatic logic word_top(logic [WORD_W-1:0] w);
      return cfg_word_16 ? w[15] : w[7];
   endfunction

   // one tick of the serial clock divider and shifter
   function automatic void serial_tick(logic miso);
      logic [2:0] steps;
      logic [8:0] period;
      if (!cfg_enable) return;
      if (!shifting) begin
         if (tx_loaded) begin
            shift_reg  = tx_word & word_mask();
            tx_loaded  = 1'b0;
            bits_to_go = cfg_word_16 ? BITS_W'(16) : BITS_W'(8);
            half_count = 8'd0;
            sck_level  = cfg_mode_high;
            mosi_level = word_top(shift_reg);
            shifting   = 1'b1;
         end
         return;
      end
      steps = (cfg_prescaler >= PRESCALER_STEPS) ? 3'(PRESCALER_STEPS - 1) : cfg_prescaler;
      period = 9'd1 << steps;
      half_count = half_count + 8'd1;
      if ({1'b0, half_count} < period) return;
      half_count = 8'd0;
      sck_level  = !sck_level;
      if (sck_level) begin
         shift_reg = ((shift_reg << 1) | WORD_W'(miso)) & word_mask();
         if (bits_to_go != 0) bits_to_go = bits_to_go - 1'b1;
      end else if (bits_to_go != 0) begin
         mosi_level = word_top(shift_reg);
      end
      // word closes once no bits remain and sck is back at idle
      if (bits_to_go == 0 && sck_level == cfg_mode_high) begin
         if (rx_loaded) overrun_seen = 1'b1;
         rx_word   = shift_reg & word_mask();
         rx_loaded = 1'b1;
         shifting  = 1'b0;
      end
   endfunction

   function automatic rsp_type next_status(op_type op, logic [WORD_W-1:0] data, logic miso);
      rsp_type r;
      r = '0;
      case (op)
         OP_TICK: serial_tick(miso);
         OP_WRITE: begin
            tx_word   = data;
            tx_loaded = 1'b1;
         end
         OP_READ_DATA: begin
            r.read_data = rx_word;
            rx_loaded   = 1'b0;
         end
         default: ;
      endcase
      // status read shows overrun before clearing it
      r.overrun = overrun_seen;
      if (op == OP_READ_STATUS) overrun_seen = 1'b0;
      r.tx_empty     = !tx_loaded;
      r.rx_not_empty = rx_loaded;
      r.busy_res     = shifting | tx_loaded;
      r.sclk_out     = shifting ? sck_level : cfg_mode_high;
      r.mosi_out     = mosi_level;
      r.select_out   = !(cfg_enable && cfg_select_oe);
      return r;
   endfunction

   function automatic void log_miss(string what, logic [WORD_W-1:0] want_v,
                                    logic [WORD_W-1:0] got_v);
      if (errors < 10)
         $display("response beat %0d: %s expected %h, got %h", beat_no, what, want_v, got_v);
      errors++;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cfg_enable    = 1'b0;
         cfg_word_16   = 1'b0;
         cfg_mode_high = 1'b0;
         cfg_prescaler = 3'd0;
         cfg_select_oe = 1'b0;
         tx_word       = '0;
         tx_loaded     = 1'b0;
         shift_reg     = '0;
         rx_word       = '0;
         rx_loaded     = 1'b0;
         overrun_seen  = 1'b0;
         bits_to_go    = '0;
         half_count    = '0;
         sck_level     = 1'b0;
         shifting      = 1'b0;
         mosi_level    = 1'b0;
         status_due.delete();
         errors        = 0;
         beat_no       = 0;
         error_count  <= 0;
         beats_owed   <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ENABLE:          cfg_enable    = csr_write_data[0];
               CSR_WORD_16:         cfg_word_16   = csr_write_data[0];
               CSR_CLOCK_MODE_HIGH: cfg_mode_high = csr_write_data[0];
               CSR_PRESCALER:       cfg_prescaler = csr_write_data[2:0];
               CSR_SELECT_OE:       cfg_select_oe = csr_write_data[0];
               default: ;
            endcase
         end
         // compare before predicting so a fresh request never matches this beat
         if (pop && !empty) begin
            got.read_data    = rsp_read_data;
            got.tx_empty     = rsp_tx_empty;
            got.rx_not_empty = rsp_rx_not_empty;
            got.busy_res     = rsp_busy_res;
            got.overrun      = rsp_overrun;
            got.sclk_out     = rsp_sclk_out;
            got.mosi_out     = rsp_mosi_out;
            got.select_out   = rsp_select_out;
            if (status_due.size() == 0) begin
               log_miss("beat with nothing pending", '0, got.read_data);
            end else begin
               want = status_due.pop_front();
               if (got.read_data !== want.read_data)
                  log_miss("read_data", want.read_data, got.read_data);
               if (got.tx_empty !== want.tx_empty)
                  log_miss("tx_empty", WORD_W'(want.tx_empty), WORD_W'(got.tx_empty));
               if (got.rx_not_empty !== want.rx_not_empty)
                  log_miss("rx_not_empty", WORD_W'(want.rx_not_empty),
                           WORD_W'(got.rx_not_empty));
               if (got.busy_res !== want.busy_res)
                  log_miss("busy_res", WORD_W'(want.busy_res), WORD_W'(got.busy_res));
               if (got.overrun !== want.overrun)
                  log_miss("overrun", WORD_W'(want.overrun), WORD_W'(got.overrun));
               if (got.sclk_out !== want.sclk_out)
                  log_miss("sclk_out", WORD_W'(want.sclk_out), WORD_W'(got.sclk_out));
               if (got.mosi_out !== want.mosi_out)
                  log_miss("mosi_out", WORD_W'(want.mosi_out), WORD_W'(got.mosi_out));
               if (got.select_out !== want.select_out)
                  log_miss("select_out", WORD_W'(want.select_out),
                           WORD_W'(got.select_out));
            end
            beat_no++;
         end
         if (push && !full)
            status_due.push_back(next_status(op_type'(req_operation), req_write_data,
                                             req_miso_in));
         error_count <= errors;
         beats_owed  <= status_due.size();
      end
   end

endmodule

// ===== bench/spi_master_controller_test.sv =====
// stimulus, clock, reset and verdict for the spi master controller
module spi_master_controller_test;
   import spim_pkg::*;

   // generous bound: every beat waiting out both sides' longest gaps, plus holds
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // response lags request through both queues, leave a margin
   localparam int unsigned DRAIN_CYCLES = 6;
   // long receiver hold, enough to fill both internal queues
   localparam int unsigned LONG_HOLD    = 300;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   push             = 1'b0;
   logic                   full;
   logic [1:0]             req_operation    = '0;
   logic [WORD_W-1:0]      req_write_data   = '0;
   logic                   req_miso_in      = 1'b0;
   logic                   empty;
   logic                   pop              = 1'b0;
   logic [WORD_W-1:0]      rsp_read_data;
   logic                   rsp_tx_empty;
   logic                   rsp_rx_not_empty;
   logic                   rsp_busy_res;
   logic                   rsp_overrun;
   logic                   rsp_sclk_out;
   logic                   rsp_mosi_out;
   logic                   rsp_select_out;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   int unsigned error_count;
   int unsigned beats_owed;
   int unsigned cycle_count = 0;

   // sender runs without gaps while this is set
   logic sender_rush = 1'b0;

   spi_master_controller u_top (.*);

   spi_master_controller_check u_check (.*);

   // 4 unit period
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: random pop gaps, two long holds, and stretches of steady pops
   initial begin : drain_side
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, 15);
         // every fourth block of 200 beats pops back to back
         if ((taken / 200) % 4 == 3) gap = 0;
         // hold off long so the block backs up and raises full
         if (taken == 400 || taken == 1500) gap = LONG_HOLD;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         taken++;
      end
   end

   // offer one request beat after a random gap, return once it is taken
   task automatic send(op_type op, logic [WORD_W-1:0] data, logic miso);
      int unsigned gap;
      gap = $urandom_range(0, 15);
      // about half the beats follow without a gap
      if (sender_rush || $urandom_range(0, 1) == 1) gap = 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1'b1;
      req_operation  <= op;
      req_write_data <= data;
      req_miso_in    <= miso;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // stop offering and wait until every predicted beat has come back
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // reprogram all five registers while the block is quiet
   task automatic program_spi(logic en, logic w16, logic mode_hi, logic [2:0] presc,
                              logic sel_oe);
      wait_idle();
      csr_put(CSR_ENABLE, CSR_DATA_W'(en));
      csr_put(CSR_WORD_16, CSR_DATA_W'(w16));
      csr_put(CSR_CLOCK_MODE_HIGH, CSR_DATA_W'(mode_hi));
      csr_put(CSR_PRESCALER, presc);
      csr_put(CSR_SELECT_OE, CSR_DATA_W'(sel_oe));
      csr_write_enable <= 1'b0;
   endtask

   // mostly ticks so words get shifted out, with writes and reads mixed in
   task automatic random_traffic(int unsigned count);
      int unsigned pick;
      op_type      op;
      for (int unsigned i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      op = OP_TICK;
         else if (pick < 82) op = OP_WRITE;
         else if (pick < 92) op = OP_READ_DATA;
         else                op = OP_READ_STATUS;
         send(op, WORD_W'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // disabled: reads at reset, buffered writes, frozen ticks
      program_spi(1'b0, 1'b0, 1'b0, 3'd0, 1'b1);
      send(OP_READ_STATUS, 16'h0000, 1'b0);
      send(OP_READ_DATA, 16'h0000, 1'b0);
      send(OP_WRITE, 16'hffff, 1'b1);
      // second write replaces the waiting word
      send(OP_WRITE, 16'h00a5, 1'b0);
      send(OP_TICK, 16'hffff, 1'b1);
      send(OP_TICK, 16'h0000, 1'b0);
      send(OP_READ_STATUS, 16'h0000, 1'b0);

      // enabled, mode 0, fastest sck: load plus one full 8-bit word
      program_spi(1'b1, 1'b0, 1'b0, 3'd0, 1'b1);
      for (int i = 0; i < 17; i++)
         send(OP_TICK, 16'h0000, 1'(i % 2));
      send(OP_READ_STATUS, 16'h0000, 1'b0);
      send(OP_READ_DATA, 16'h0000, 1'b0);

      // random phases across the register space
      program_spi(1'b1, 1'b0, 1'b0, 3'd0, 1'b1);
      random_traffic(300);
      program_spi(1'b1, 1'b1, 1'b1, 3'd1, 1'b0);
      random_traffic(300);
      // mode flip while a word may still be in flight
      program_spi(1'b1, 1'b0, 1'b1, 3'd2, 1'b1);
      random_traffic(250);
      program_spi(1'b1, 1'b1, 1'b0, 3'd0, 1'b1);
      random_traffic(150);
      // sender pause until the response side has caught up
      wait_idle();
      random_traffic(150);
      // disabled again: any transfer under way freezes
      program_spi(1'b0, 1'b1, 1'b0, 3'd3, 1'b1);
      random_traffic(80);
      // slowest sck, back to back
      sender_rush <= 1'b1;
      program_spi(1'b1, 1'b1, 1'b1, 3'd7, 1'b1);
      random_traffic(300);
      sender_rush <= 1'b0;
      program_spi(1'b1, 1'b0, 1'b0, 3'd1, 1'b0);
      random_traffic(400);

      wait_idle();
      if (error_count == 0 && beats_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
